/* src/gpsflt_pkg.sv */
// Shared types, status codes and the cosine table of the GPS fix filter.
`timescale 1ns / 1ps

package gpsflt_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_FORCED   = 3'd1,
        ST_STALE    = 3'd2,
        ST_NO_TIME  = 3'd3,
        ST_FEW_SATS = 3'd4,
        ST_HIGH_DOP = 3'd5,
        ST_INTERVAL = 3'd6,
        ST_JUMP     = 3'd7
    } t_status;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_EMIT_INTERVAL = 3'd0;
    localparam logic [2:0] REG_MIN_SATS      = 3'd1;
    localparam logic [2:0] REG_MAX_HDOP      = 3'd2;
    localparam logic [2:0] REG_MAX_AGE       = 3'd3;
    localparam logic [2:0] REG_JUMP_FLOOR    = 3'd4;
    localparam logic [2:0] REG_JUMP_NOISE    = 3'd5;
    localparam logic [2:0] REG_MAX_REJECTS   = 3'd6;

    // Arithmetic constants
    localparam logic [26:0] EMIT_MIN      = 27'd500;
    localparam logic [24:0] COS_STEP      = 25'd20000000; // one degree in half-units
    localparam logic [31:0] COS_LIMIT     = 32'd1800000000;
    localparam logic [24:0] CM_DIVISOR    = 25'd10000;
    localparam logic [31:0] CM_PER_UNIT   = 32'd11132;
    localparam logic [31:0] SAT32         = 32'hFFFF_FFFF;

    // Input fix, as unpacked from the stream beat
    typedef struct packed {
        logic [31:0] longitude;
        logic [30:0] latitude;
        logic [31:0] now_ms;
        logic [13:0] hdop_x100;
        logic        hdop_valid;
        logic [5:0]  satellite_count;
        logic        satellites_valid;
        logic        date_time_valid;
        logic [15:0] location_age_ms;
        logic        location_valid;
    } t_fix;

    // Cosine in Q15, one entry per degree
    localparam logic [15:0] COS_Q15 [0:90] = '{
        16'd32768, 16'd32763, 16'd32748, 16'd32723, 16'd32688, 16'd32643, 16'd32588,
        16'd32524, 16'd32449, 16'd32365, 16'd32270, 16'd32166, 16'd32052, 16'd31928,
        16'd31795, 16'd31651, 16'd31499, 16'd31336, 16'd31164, 16'd30983, 16'd30792,
        16'd30592, 16'd30382, 16'd30163, 16'd29935, 16'd29698, 16'd29452, 16'd29197,
        16'd28932, 16'd28660, 16'd28378, 16'd28088, 16'd27789, 16'd27482, 16'd27166,
        16'd26842, 16'd26510, 16'd26170, 16'd25822, 16'd25466, 16'd25102, 16'd24730,
        16'd24351, 16'd23965, 16'd23571, 16'd23170, 16'd22763, 16'd22348, 16'd21926,
        16'd21498, 16'd21063, 16'd20622, 16'd20174, 16'd19720, 16'd19261, 16'd18795,
        16'd18324, 16'd17847, 16'd17364, 16'd16877, 16'd16384, 16'd15886, 16'd15384,
        16'd14876, 16'd14365, 16'd13848, 16'd13328, 16'd12803, 16'd12275, 16'd11743,
        16'd11207, 16'd10668, 16'd10126, 16'd9580,  16'd9032,  16'd8481,  16'd7927,
        16'd7371,  16'd6813,  16'd6252,  16'd5690,  16'd5126,  16'd4560,  16'd3993,
        16'd3425,  16'd2856,  16'd2286,  16'd1715,  16'd1144,  16'd572,   16'd0
    };

    // Look up the table, zero past ninety degrees
    function automatic logic [15:0] cos_at(input logic [6:0] idx);
        logic [15:0] v;
        v = 16'd0;
        if (idx <= 7'd90) begin
            v = COS_Q15[idx];
        end
        return v;
    endfunction

endpackage

/* src/gps_fix_quality_and_jump_filter.sv */
// GPS fix quality checks and position jump filter with bit-serial arithmetic.
`timescale 1ns / 1ps

//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | s_axis_tdata: one fix (136 bits)
//  m_axis   | out | m_axis_tvalid/tready   | m_axis_tdata: one result (136 bits)
//  apb      | in  | psel/penable/pready    | paddr, pwdata, prdata (32 bits)
//
// A fix failing a quality check, or arriving with no earlier fix, goes from the checks straight to output.
// A jump test runs up to four serial divisions, six shift-add multiplies and a
// serial square root, then a pairwise rank search over the delta history
// (one compare a cycle).
// Reset is synchronous, active low; it clears control and history bookkeeping.
// A stalled result sits in the output register while the next fix is taken.

module gps_fix_quality_and_jump_filter #(
    parameter int HISTORY_DEPTH = 5
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // location_valid, location_age_ms, date_time_valid, satellites_valid,
    // satellite_count, hdop_valid, hdop_x100, now_ms, latitude, longitude
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,
    // status, accepted_latitude, accepted_longitude, jump_distance_cm,
    // jump_threshold_cm, has_fix
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FULL     = FW'(HISTORY_DEPTH);

    typedef enum logic [18:0] {
        S_IDLE   = 19'b000_0000_0000_0000_0001,
        S_CHECK  = 19'b000_0000_0000_0000_0010,
        S_IDX    = 19'b000_0000_0000_0000_0100,
        S_CLOAD  = 19'b000_0000_0000_0000_1000,
        S_CMUL   = 19'b000_0000_0000_0001_0000,
        S_CDIV   = 19'b000_0000_0000_0010_0000,
        S_YMUL   = 19'b000_0000_0000_0100_0000,
        S_YDIV   = 19'b000_0000_0000_1000_0000,
        S_XMUL1  = 19'b000_0000_0001_0000_0000,
        S_XMUL2  = 19'b000_0000_0010_0000_0000,
        S_XDIV   = 19'b000_0000_0100_0000_0000,
        S_SQX    = 19'b000_0000_1000_0000_0000,
        S_SQY    = 19'b000_0001_0000_0000_0000,
        S_SQRT   = 19'b000_0010_0000_0000_0000,
        S_MSTART = 19'b000_0100_0000_0000_0000,
        S_MLOAD  = 19'b000_1000_0000_0000_0000,
        S_MCMP   = 19'b001_0000_0000_0000_0000,
        S_DEC    = 19'b010_0000_0000_0000_0000,
        S_OUT    = 19'b100_0000_0000_0000_0000
    } t_state;

    // Configuration
    logic [26:0] r_emit;
    logic [5:0]  r_min_sats;
    logic [13:0] r_max_hdop;
    logic [15:0] r_max_age;
    logic [19:0] r_floor;
    logic [19:0] r_noise;
    logic [7:0]  r_max_rej;

    // Filter state
    logic [30:0]   r_prev_lat;
    logic [31:0]   r_prev_lon;
    logic          r_have_prev;
    logic          r_fix_seen;
    logic [31:0]   r_last_emit;
    logic [31:0]   r_hist [HISTORY_DEPTH];
    logic [IW-1:0] r_widx;
    logic [FW-1:0] r_fill;
    logic [7:0]    r_rej;

    // Sequencer and datapath
    t_state r_state, n_state;
    gpsflt_pkg::t_fix r_fix;
    gpsflt_pkg::t_status r_stat, n_stat;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_dlat, n_dlat, r_dlon, n_dlon;
    logic [6:0]  r_idx, n_idx;
    logic [15:0] r_c, n_c;
    logic [33:0] r_dx, n_dx, r_dy, n_dy;
    logic [63:0] r_sq, n_sq;
    logic [63:0] r_ma, n_ma, r_mp, n_mp;
    logic [31:0] r_mb, n_mb;
    logic [63:0] r_dn, n_dn;
    logic [24:0] r_drem, n_drem;
    logic [63:0] r_sx, n_sx, r_sr, n_sr, r_sb, n_sb;
    logic [31:0] r_dist, n_dist, r_thr, n_thr, r_med, n_med, r_cand, n_cand;
    logic [IW-1:0] r_mi, n_mi, r_mj, n_mj;
    logic [FW-1:0] r_lt, n_lt, r_le, n_le;

    // Output register
    logic         r_mvalid;
    logic [135:0] r_mdata;

    // Position and bookkeeping updates
    logic w_commit, w_hist_we, w_rej_inc, w_rej_clr;

    logic        w_cfg_we;
    logic [26:0] w_emit_wr;
    logic [24:0] w_den;
    logic [25:0] w_rem_sh;
    logic        w_qbit;
    logic [63:0] w_sq_try;
    logic        w_sq_ge;
    logic [IW-1:0] w_raddr;
    logic [31:0] w_hval;
    logic [FW-1:0] w_lt2, w_le2, w_k, w_last;
    logic [32:0] w_lat_d, w_lon_d;
    logic [31:0] w_lat_s;
    logic [31:0] w_as;
    logic [31:0] w_since;
    logic [32:0] w_twice, w_base;
    logic [33:0] w_tsum;
    logic [31:0] w_thr;
    logic [64:0] w_sum;
    logic        w_out_free;

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign w_out_free    = !r_mvalid || m_axis_tready;

    // Configuration write and read
    assign w_cfg_we  = psel && penable && pwrite && pready;
    assign w_emit_wr = (pwdata[26:0] < gpsflt_pkg::EMIT_MIN) ? gpsflt_pkg::EMIT_MIN
                                                             : pwdata[26:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit     <= 27'd60000;
            r_min_sats <= 6'd4;
            r_max_hdop <= 14'd1000;
            r_max_age  <= 16'd5000;
            r_floor    <= 20'd1000;
            r_noise    <= 20'd2000;
            r_max_rej  <= 8'd3;
        end else if (w_cfg_we) begin
            case (paddr[4:2])
                gpsflt_pkg::REG_EMIT_INTERVAL: r_emit     <= w_emit_wr;
                gpsflt_pkg::REG_MIN_SATS:      r_min_sats <= pwdata[5:0];
                gpsflt_pkg::REG_MAX_HDOP:      r_max_hdop <= pwdata[13:0];
                gpsflt_pkg::REG_MAX_AGE:       r_max_age  <= pwdata[15:0];
                gpsflt_pkg::REG_JUMP_FLOOR:    r_floor    <= pwdata[19:0];
                gpsflt_pkg::REG_JUMP_NOISE:    r_noise    <= pwdata[19:0];
                gpsflt_pkg::REG_MAX_REJECTS:   r_max_rej  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            gpsflt_pkg::REG_EMIT_INTERVAL: prdata = {5'd0, r_emit};
            gpsflt_pkg::REG_MIN_SATS:      prdata = {26'd0, r_min_sats};
            gpsflt_pkg::REG_MAX_HDOP:      prdata = {18'd0, r_max_hdop};
            gpsflt_pkg::REG_MAX_AGE:       prdata = {16'd0, r_max_age};
            gpsflt_pkg::REG_JUMP_FLOOR:    prdata = {12'd0, r_floor};
            gpsflt_pkg::REG_JUMP_NOISE:    prdata = {12'd0, r_noise};
            gpsflt_pkg::REG_MAX_REJECTS:   prdata = {24'd0, r_max_rej};
            default:                       prdata = 32'd0;
        endcase
    end

    // Serial divider step: one quotient bit per cycle
    assign w_den    = (r_state == S_IDX || r_state == S_CDIV) ? gpsflt_pkg::COS_STEP
                                                               : gpsflt_pkg::CM_DIVISOR;
    assign w_rem_sh = {r_drem, r_dn[63]};
    assign w_qbit   = (w_rem_sh >= {1'b0, w_den});

    // Square root step: two radicand bits per cycle
    assign w_sq_try = r_sr + r_sb;
    assign w_sq_ge  = (r_sx >= w_sq_try);

    // History read port, one address a cycle
    assign w_raddr = (r_state == S_MLOAD) ? r_mi : r_mj;
    assign w_hval  = r_hist[w_raddr];
    assign w_lt2   = r_lt + FW'(w_hval < r_cand);
    assign w_le2   = r_le + FW'(w_hval <= r_cand);
    assign w_k     = r_fill >> 1;
    assign w_last  = r_fill - FW'(1);

    // Quality check operands
    assign w_lat_d = {{2{r_prev_lat[30]}}, r_prev_lat} - {{2{r_fix.latitude[30]}}, r_fix.latitude};
    assign w_lon_d = {r_prev_lon[31], r_prev_lon} - {r_fix.longitude[31], r_fix.longitude};
    assign w_lat_s = {r_prev_lat[30], r_prev_lat} + {r_fix.latitude[30], r_fix.latitude};
    assign w_as    = w_lat_s[31] ? (32'd0 - w_lat_s) : w_lat_s;
    assign w_since = r_fix.now_ms - r_last_emit;

    // Threshold from the median
    assign w_twice = {r_med, 1'b0};
    assign w_base  = (w_twice > {13'd0, r_floor}) ? w_twice : {13'd0, r_floor};
    assign w_tsum  = {1'b0, w_base} + {14'd0, r_noise};
    assign w_thr   = (w_tsum[33:32] != 2'd0) ? gpsflt_pkg::SAT32 : w_tsum[31:0];

    assign w_sum = {1'b0, r_sq} + {1'b0, r_mp + (r_mb[0] ? r_ma : 64'd0)};

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_stat  = r_stat;
        n_cnt   = r_cnt + 6'd1;
        n_dlat  = r_dlat;
        n_dlon  = r_dlon;
        n_idx   = r_idx;
        n_c     = r_c;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_sq    = r_sq;
        n_ma    = r_ma << 1;
        n_mb    = r_mb >> 1;
        n_mp    = r_mp + (r_mb[0] ? r_ma : 64'd0);
        n_dn    = {r_dn[62:0], w_qbit};
        n_drem  = w_qbit ? 25'(w_rem_sh - {1'b0, w_den}) : w_rem_sh[24:0];
        n_sx    = w_sq_ge ? (r_sx - w_sq_try) : r_sx;
        n_sr    = w_sq_ge ? ((r_sr >> 1) + r_sb) : (r_sr >> 1);
        n_sb    = r_sb >> 2;
        n_dist  = r_dist;
        n_thr   = r_thr;
        n_med   = r_med;
        n_cand  = r_cand;
        n_mi    = r_mi;
        n_mj    = r_mj;
        n_lt    = r_lt;
        n_le    = r_le;
        w_commit  = 1'b0;
        w_hist_we = 1'b0;
        w_rej_inc = 1'b0;
        w_rej_clr = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_CHECK;
                end
            end
            // Run the quality checks in order
            S_CHECK: begin
                n_dist = 32'd0;
                n_thr  = 32'd0;
                n_cnt  = 6'd0;
                n_state = S_OUT;
                if (!r_fix.location_valid || r_fix.location_age_ms > r_max_age) begin
                    n_stat = gpsflt_pkg::ST_STALE;
                end else if (!r_fix.date_time_valid) begin
                    n_stat = gpsflt_pkg::ST_NO_TIME;
                end else if (r_fix.satellites_valid && r_fix.satellite_count < r_min_sats) begin
                    n_stat = gpsflt_pkg::ST_FEW_SATS;
                end else if (r_fix.hdop_valid && r_fix.hdop_x100 > r_max_hdop) begin
                    n_stat = gpsflt_pkg::ST_HIGH_DOP;
                end else if (r_fix_seen && w_since < {5'd0, r_emit}) begin
                    n_stat = gpsflt_pkg::ST_INTERVAL;
                end else begin
                    n_stat = gpsflt_pkg::ST_ACCEPTED;
                    if (!r_have_prev) begin
                        w_commit = 1'b1;
                    end else begin
                        n_dlat = w_lat_d[32] ? 32'(33'd0 - w_lat_d) : w_lat_d[31:0];
                        n_dlon = w_lon_d[32] ? 32'(33'd0 - w_lon_d) : w_lon_d[31:0];
                        if (w_as < gpsflt_pkg::COS_LIMIT) begin
                            n_dn    = {32'd0, w_as};
                            n_drem  = 25'd0;
                            n_state = S_IDX;
                        end else begin
                            n_c     = 16'd0;
                            n_ma    = {32'd0, n_dlat};
                            n_mb    = gpsflt_pkg::CM_PER_UNIT;
                            n_mp    = 64'd0;
                            n_state = S_YMUL;
                        end
                    end
                end
            end
            // Table index and fraction of the mean latitude
            S_IDX: begin
                if (r_cnt == 6'd63) begin
                    n_idx   = n_dn[6:0];
                    n_state = S_CLOAD;
                end
            end
            S_CLOAD: begin
                n_ma    = {39'd0, r_drem};
                n_mb    = {16'd0, gpsflt_pkg::cos_at(r_idx) - gpsflt_pkg::cos_at(r_idx + 7'd1)};
                n_mp    = 64'd0;
                n_cnt   = 6'd0;
                n_state = S_CMUL;
            end
            S_CMUL: begin
                if (r_cnt == 6'd31) begin
                    n_dn    = n_mp;
                    n_drem  = 25'd0;
                    n_cnt   = 6'd0;
                    n_state = S_CDIV;
                end
            end
            S_CDIV: begin
                if (r_cnt == 6'd63) begin
                    n_c     = gpsflt_pkg::cos_at(r_idx) - n_dn[15:0];
                    n_ma    = {32'd0, r_dlat};
                    n_mb    = gpsflt_pkg::CM_PER_UNIT;
                    n_mp    = 64'd0;
                    n_cnt   = 6'd0;
                    n_state = S_YMUL;
                end
            end
            // North-south distance
            S_YMUL: begin
                if (r_cnt == 6'd31) begin
                    n_dn    = n_mp;
                    n_drem  = 25'd0;
                    n_cnt   = 6'd0;
                    n_state = S_YDIV;
                end
            end
            S_YDIV: begin
                if (r_cnt == 6'd63) begin
                    n_dy    = n_dn[33:0];
                    n_ma    = {32'd0, r_dlon};
                    n_mb    = gpsflt_pkg::CM_PER_UNIT;
                    n_mp    = 64'd0;
                    n_cnt   = 6'd0;
                    n_state = S_XMUL1;
                end
            end
            // East-west distance scaled by the cosine
            S_XMUL1: begin
                if (r_cnt == 6'd31) begin
                    n_ma    = n_mp;
                    n_mb    = {16'd0, r_c};
                    n_mp    = 64'd0;
                    n_cnt   = 6'd0;
                    n_state = S_XMUL2;
                end
            end
            S_XMUL2: begin
                if (r_cnt == 6'd31) begin
                    n_dn    = n_mp >> 15;
                    n_drem  = 25'd0;
                    n_cnt   = 6'd0;
                    n_state = S_XDIV;
                end
            end
            S_XDIV: begin
                if (r_cnt == 6'd63) begin
                    n_dx  = n_dn[33:0];
                    n_cnt = 6'd0;
                    if (n_dn[63:32] != 32'd0 || r_dy[33:32] != 2'd0) begin
                        n_dist  = gpsflt_pkg::SAT32;
                        n_state = S_MSTART;
                    end else begin
                        n_ma    = {32'd0, n_dn[31:0]};
                        n_mb    = n_dn[31:0];
                        n_mp    = 64'd0;
                        n_state = S_SQX;
                    end
                end
            end
            // Sum of squares
            S_SQX: begin
                if (r_cnt == 6'd31) begin
                    n_sq    = n_mp;
                    n_ma    = {32'd0, r_dy[31:0]};
                    n_mb    = r_dy[31:0];
                    n_mp    = 64'd0;
                    n_cnt   = 6'd0;
                    n_state = S_SQY;
                end
            end
            S_SQY: begin
                if (r_cnt == 6'd31) begin
                    n_cnt = 6'd0;
                    if (w_sum[64]) begin
                        n_dist  = gpsflt_pkg::SAT32;
                        n_state = S_MSTART;
                    end else begin
                        n_sx    = w_sum[63:0];
                        n_sr    = 64'd0;
                        n_sb    = 64'd1 << 62;
                        n_state = S_SQRT;
                    end
                end
            end
            S_SQRT: begin
                if (r_cnt == 6'd31) begin
                    n_dist  = n_sr[31:0];
                    n_state = S_MSTART;
                end
            end
            // Upper median by rank search over the kept deltas
            S_MSTART: begin
                n_mi = '0;
                if (r_fill == '0) begin
                    n_med   = 32'd0;
                    n_state = S_DEC;
                end else begin
                    n_state = S_MLOAD;
                end
            end
            S_MLOAD: begin
                n_cand  = w_hval;
                n_mj    = '0;
                n_lt    = '0;
                n_le    = '0;
                n_state = S_MCMP;
            end
            S_MCMP: begin
                n_lt = w_lt2;
                n_le = w_le2;
                n_mj = r_mj + IW'(1);
                if (FW'(r_mj) == w_last) begin
                    if (w_lt2 <= w_k && w_k < w_le2) begin
                        n_med   = r_cand;
                        n_state = S_DEC;
                    end else begin
                        n_mi    = r_mi + IW'(1);
                        n_state = S_MLOAD;
                    end
                end
            end
            // Jump decision
            S_DEC: begin
                n_thr   = w_thr;
                n_state = S_OUT;
                if (r_dist > w_thr && r_rej < r_max_rej) begin
                    n_stat    = gpsflt_pkg::ST_JUMP;
                    w_rej_inc = 1'b1;
                end else begin
                    w_rej_clr = 1'b1;
                    w_commit  = 1'b1;
                    if (r_dist > w_thr) begin
                        n_stat = gpsflt_pkg::ST_FORCED;
                    end else begin
                        n_stat    = gpsflt_pkg::ST_ACCEPTED;
                        w_hist_we = 1'b1;
                    end
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_prev_lat  <= '0;
            r_prev_lon  <= '0;
            r_have_prev <= 1'b0;
            r_fix_seen  <= 1'b0;
            r_last_emit <= '0;
            r_widx      <= '0;
            r_fill      <= '0;
            r_rej       <= '0;
            r_mvalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_prev_lat  <= r_fix.latitude;
                r_prev_lon  <= r_fix.longitude;
                r_have_prev <= 1'b1;
                r_fix_seen  <= 1'b1;
                r_last_emit <= r_fix.now_ms;
            end
            if (w_hist_we) begin
                r_widx <= (r_widx == LAST_IDX) ? '0 : r_widx + IW'(1);
                if (r_fill < FULL) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
            if (w_rej_inc) begin
                r_rej <= r_rej + 8'd1;
            end else if (w_rej_clr) begin
                r_rej <= 8'd0;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_fix <= s_axis_tdata[134:0];
        end
        if (w_hist_we) begin
            r_hist[r_widx] <= r_dist;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_mdata <= {5'd0, r_fix_seen, r_thr, r_dist, r_prev_lon, r_prev_lat, r_stat};
        end
        r_stat <= n_stat;
        r_cnt  <= n_cnt;
        r_dlat <= n_dlat;
        r_dlon <= n_dlon;
        r_idx  <= n_idx;
        r_c    <= n_c;
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_sq   <= n_sq;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_mp   <= n_mp;
        r_dn   <= n_dn;
        r_drem <= n_drem;
        r_sx   <= n_sx;
        r_sr   <= n_sr;
        r_sb   <= n_sb;
        r_dist <= n_dist;
        r_thr  <= n_thr;
        r_med  <= n_med;
        r_cand <= n_cand;
        r_mi   <= n_mi;
        r_mj   <= n_mj;
        r_lt   <= n_lt;
        r_le   <= n_le;
    end

`ifndef SYNTHESIS
    // An accepted beat always starts the quality checks
    a_start_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_state == S_CHECK)
        else $error("fix accepted without entering the checks");

    // The history never reports more entries than it holds
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("history fill beyond depth");

    // A rejected jump shows a distance above its threshold
    a_jump_gt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mvalid && r_mdata[2:0] == gpsflt_pkg::ST_JUMP |-> r_mdata[97:66] > r_mdata[129:98])
        else $error("jump rejected within threshold");

    // Accepted results carry a fix
    a_accept_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mvalid && (r_mdata[2:0] == gpsflt_pkg::ST_ACCEPTED ||
                     r_mdata[2:0] == gpsflt_pkg::ST_FORCED) |-> r_mdata[130])
        else $error("accepted result without a fix");
`endif

endmodule

/* tb/sv/tb_gps_fix_quality_and_jump_filter.sv */
// Self-checking testbench for the GPS fix quality and jump filter.
`timescale 1ns / 1ps

module tb_gps_fix_quality_and_jump_filter;

    // One expected result beat
    typedef struct {
        gpsflt_pkg::t_status status;
        logic [30:0] lat;
        logic [31:0] lon;
        logic [31:0] dist_cm;
        logic [31:0] thr;
        logic        has_fix;
    } t_fix_verdict;

    // Filter predictor plus the queue of verdicts still owed by the block
    class t_fix_scoreboard;
        int unsigned emit_ms, min_sats, max_hdop, max_age, floor_cm, noise_cm, max_rej;
        longint      last_lat, last_lon;
        bit          have_prev, fix_seen;
        bit [31:0]   last_emit;
        int unsigned deltas [5];
        int unsigned wr_idx, fill, reject_run;
        t_fix_verdict owed [$];
        int          errors;
        int          seen_status [8];

        function new();
            emit_ms = 60000; min_sats = 4; max_hdop = 1000; max_age = 5000;
            floor_cm = 1000; noise_cm = 2000; max_rej = 3;
            last_lat = 0; last_lon = 0; have_prev = 0; fix_seen = 0; last_emit = 0;
            wr_idx = 0; fill = 0; reject_run = 0; errors = 0;
            foreach (seen_status[i]) seen_status[i] = 0;
        endfunction

        // Mirror a register write, dropping unknown indexes
        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                gpsflt_pkg::REG_EMIT_INTERVAL:
                    emit_ms = 32'((val[26:0] < gpsflt_pkg::EMIT_MIN) ? gpsflt_pkg::EMIT_MIN
                                                                      : val[26:0]);
                gpsflt_pkg::REG_MIN_SATS:      min_sats = 32'(val[5:0]);
                gpsflt_pkg::REG_MAX_HDOP:      max_hdop = 32'(val[13:0]);
                gpsflt_pkg::REG_MAX_AGE:       max_age  = 32'(val[15:0]);
                gpsflt_pkg::REG_JUMP_FLOOR:    floor_cm = 32'(val[19:0]);
                gpsflt_pkg::REG_JUMP_NOISE:    noise_cm = 32'(val[19:0]);
                gpsflt_pkg::REG_MAX_REJECTS:   max_rej  = 32'(val[7:0]);
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Equirectangular distance in cm, saturating at 32 bits
        function bit [31:0] span_cm(longint la1, longint lo1, longint la2, longint lo2);
            longint unsigned dlat, dlon, asum, c, idx, fr, d, dy, dx, a, sum, r;
            longint s;
            dlat = (la1 >= la2) ? la1 - la2 : la2 - la1;
            dlon = (lo1 >= lo2) ? lo1 - lo2 : lo2 - lo1;
            s = la1 + la2;
            asum = (s >= 0) ? s : -s;
            c = 0;
            if (asum < 64'd1800000000) begin
                idx = asum / 64'd20000000;
                fr = asum % 64'd20000000;
                d = gpsflt_pkg::COS_Q15[idx] - gpsflt_pkg::COS_Q15[idx + 1];
                c = gpsflt_pkg::COS_Q15[idx] - (d * fr) / 64'd20000000;
            end
            dy = dlat * 64'd11132 / 64'd10000;
            dx = ((dlon * 64'd11132 * c) >> 15) / 64'd10000;
            if (dx > 64'hFFFF_FFFF || dy > 64'hFFFF_FFFF) return gpsflt_pkg::SAT32;
            a = dx * dx;
            sum = a + dy * dy;
            if (sum < a) return gpsflt_pkg::SAT32;
            r = int_sqrt(sum);
            return (r > 64'hFFFF_FFFF) ? gpsflt_pkg::SAT32 : r[31:0];
        endfunction

        function int unsigned upper_median();
            int unsigned v [5];
            int unsigned x;
            int i, j;
            if (fill == 0) return 0;
            for (i = 0; i < fill; i++) v[i] = deltas[i];
            for (i = 1; i < fill; i++) begin
                x = v[i];
                j = i;
                while (j > 0 && v[j-1] > x) begin
                    v[j] = v[j-1];
                    j--;
                end
                v[j] = x;
            end
            return v[fill / 2];
        endfunction

        // Note an accepted fix and queue the verdict it must produce
        function void note_fix(gpsflt_pkg::t_fix f);
            t_fix_verdict e;
            longint la, lo;
            longint unsigned twice, base, t;
            bit [31:0] gap;
            la = $signed(f.latitude);
            lo = $signed(f.longitude);
            gap = f.now_ms - last_emit;
            e.dist_cm = 0;
            e.thr = 0;
            if (!f.location_valid || f.location_age_ms > max_age)
                e.status = gpsflt_pkg::ST_STALE;
            else if (!f.date_time_valid)
                e.status = gpsflt_pkg::ST_NO_TIME;
            else if (f.satellites_valid && f.satellite_count < min_sats)
                e.status = gpsflt_pkg::ST_FEW_SATS;
            else if (f.hdop_valid && f.hdop_x100 > max_hdop)
                e.status = gpsflt_pkg::ST_HIGH_DOP;
            else if (fix_seen && gap < emit_ms)
                e.status = gpsflt_pkg::ST_INTERVAL;
            else begin
                e.status = gpsflt_pkg::ST_ACCEPTED;
                if (have_prev) begin
                    e.dist_cm = span_cm(last_lat, last_lon, la, lo);
                    twice = 2 * longint'(upper_median());
                    base = (twice > floor_cm) ? twice : floor_cm;
                    t = base + noise_cm;
                    e.thr = (t > 64'hFFFF_FFFF) ? gpsflt_pkg::SAT32 : t[31:0];
                    if (e.dist_cm > e.thr && reject_run < max_rej) begin
                        reject_run++;
                        e.status = gpsflt_pkg::ST_JUMP;
                    end else begin
                        reject_run = 0;
                        if (e.dist_cm > e.thr) begin
                            e.status = gpsflt_pkg::ST_FORCED;
                        end else begin
                            deltas[wr_idx] = e.dist_cm;
                            wr_idx = (wr_idx + 1) % 5;
                            if (fill < 5) fill++;
                        end
                    end
                end
                if (e.status != gpsflt_pkg::ST_JUMP) begin
                    last_lat = la;
                    last_lon = lo;
                    have_prev = 1;
                    fix_seen = 1;
                    last_emit = f.now_ms;
                end
            end
            e.lat = last_lat[30:0];
            e.lon = last_lon[31:0];
            e.has_fix = fix_seen;
            seen_status[e.status]++;
            owed.push_back(e);
        endfunction

        // Compare one result beat against the oldest owed verdict
        function void check_result(logic [135:0] d);
            t_fix_verdict e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, d);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (d[2:0] !== e.status || d[33:3] !== e.lat || d[65:34] !== e.lon ||
                d[97:66] !== e.dist_cm || d[129:98] !== e.thr || d[130] !== e.has_fix) begin
                $display("%0t: mismatch expected st=%0d lat=%h lon=%h dist=%0d thr=%0d fix=%0b",
                         $time, e.status, e.lat, e.lon, e.dist_cm, e.thr, e.has_fix);
                $display("%0t:          actual   st=%0d lat=%h lon=%h dist=%0d thr=%0d fix=%0b",
                         $time, d[2:0], d[33:3], d[65:34], d[97:66], d[129:98], d[130]);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;   // t_fix, location_valid in bit 0, bit 135 zero
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;   // status, lat, lon, distance, threshold, has_fix
    logic         psel, penable, pwrite, pready;
    logic [4:0]   paddr;
    logic [31:0]  pwdata, prdata;

    t_fix_scoreboard sb;
    int        idle_mode;   // 0: light sender gaps, 1: heavy sender gaps, 2: none
    int        hold_ask, hold_done, hold_left;
    int        sent;
    longint    walk_lat, walk_lon;
    bit [31:0] walk_now;

    gps_fix_quality_and_jump_filter u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver: random back-pressure, long hold-off on request, check each beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ask != hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left <= 3000;
            hold_done <= hold_ask;
        end else begin
            m_axis_tready <= (idle_mode == 0) ? ($urandom_range(0, 99) >= 54) :
                             (idle_mode == 1) ? ($urandom_range(0, 99) >= 14) : 1'b1;
        end
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    // Setup and access phase, then back to idle
    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, val);
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain all owed results, then let the block settle before a write
    task automatic drain();
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic send_fix(gpsflt_pkg::t_fix f);
        int gap;
        idle_mode = (sent < 550) ? 0 : (sent < 1100) ? 1 : 2;
        gap = 0;
        if (idle_mode == 0 && $urandom_range(0, 99) < 14) gap = $urandom_range(1, 4);
        if (idle_mode == 1 && $urandom_range(0, 99) < 54) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, f};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_fix(f);
        sent++;
    endtask

    function automatic gpsflt_pkg::t_fix mk(int unsigned lv, int unsigned age, int unsigned dt,
                                            int unsigned sv, int unsigned sats,
                                            int unsigned hv, int unsigned hdop, bit [31:0] now,
                                            longint lat, longint lon);
        gpsflt_pkg::t_fix f;
        f.location_valid = lv[0];  f.location_age_ms = age[15:0]; f.date_time_valid = dt[0];
        f.satellites_valid = sv[0]; f.satellite_count = sats[5:0];
        f.hdop_valid = hv[0]; f.hdop_x100 = hdop[13:0]; f.now_ms = now;
        f.latitude = lat[30:0]; f.longitude = lon[31:0];
        return f;
    endfunction

    // Mostly plausible fixes along a walk, with jumps, early fixes and noise
    task automatic run_random(int n);
        gpsflt_pkg::t_fix f;
        int r;
        longint la, lo;
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                r = $urandom_range(0, 99);
                if (r < 80) begin
                    walk_lat = walk_lat + longint'($urandom_range(0, 4000)) - 2000;
                    walk_lon = walk_lon + longint'($urandom_range(0, 4000)) - 2000;
                end else if (r < 96) begin
                    walk_lat = walk_lat + longint'($urandom_range(0, 10000000)) - 5000000;
                    walk_lon = walk_lon + longint'($urandom_range(0, 10000000)) - 5000000;
                end else begin
                    walk_lat = longint'($urandom_range(0, 1800000000)) - 900000000;
                    walk_lon = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
                end
                if (walk_lat > 900000000) walk_lat = 900000000;
                if (walk_lat < -900000000) walk_lat = -900000000;
                if (walk_lon > 1800000000) walk_lon = 1800000000;
                if (walk_lon < -1800000000) walk_lon = -1800000000;
                if ($urandom_range(0, 9) == 0)
                    walk_now = walk_now + $urandom_range(0, sb.emit_ms - 1);
                else
                    walk_now = walk_now + sb.emit_ms + $urandom_range(0, 3000);
                f = mk(1, $urandom_range(0, sb.max_age), 1, $urandom_range(0, 1),
                       $urandom_range(sb.min_sats, 63), $urandom_range(0, 1),
                       $urandom_range(0, sb.max_hdop), walk_now, walk_lat, walk_lon);
            end else begin
                la = longint'($urandom_range(0, 1800000000)) - 900000000;
                lo = longint'($urandom_range(0, 32'd3600000000)) - 1800000000;
                f = mk($urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 1),
                       $urandom_range(0, 1), $urandom_range(0, 63), $urandom_range(0, 1),
                       $urandom_range(0, 9999), $urandom(), la, lo);
            end
            send_fix(f);
        end
    endtask

    task automatic write_all(int unsigned e, int unsigned s, int unsigned h, int unsigned a,
                             int unsigned fl, int unsigned nz, int unsigned rj);
        apb_write(gpsflt_pkg::REG_EMIT_INTERVAL, e);
        apb_write(gpsflt_pkg::REG_MIN_SATS, s);
        apb_write(gpsflt_pkg::REG_MAX_HDOP, h);
        apb_write(gpsflt_pkg::REG_MAX_AGE, a);
        apb_write(gpsflt_pkg::REG_JUMP_FLOOR, fl);
        apb_write(gpsflt_pkg::REG_JUMP_NOISE, nz);
        apb_write(gpsflt_pkg::REG_MAX_REJECTS, rj);
    endtask

    initial begin
        bit [31:0] t;
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        idle_mode = 0; hold_ask = 0; hold_done = 0; hold_left = 0; sent = 0;
        walk_lat = 473000000; walk_lon = 85000000; walk_now = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every rejection reason, wrap of time, rejects, force, extremes
        t = 32'hFFFD_0000;
        send_fix(mk(0, 0, 1, 1, 10, 1, 100, t, 0, 0));
        send_fix(mk(1, 5001, 1, 1, 10, 1, 100, t, 0, 0));
        send_fix(mk(1, 65535, 1, 1, 10, 1, 100, t, 0, 0));
        send_fix(mk(1, 0, 0, 1, 10, 1, 100, t, 0, 0));
        send_fix(mk(1, 0, 1, 1, 3, 1, 100, t, 0, 0));
        send_fix(mk(1, 5000, 1, 0, 0, 1, 1001, t, 0, 0));
        send_fix(mk(1, 0, 1, 1, 63, 1, 9999, t, 0, 0));
        send_fix(mk(1, 0, 1, 0, 0, 0, 16383, t, 0, 0));
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t + 59999, 10, 10));
        t = t + 70000;
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, 500, 700));
        t = t + 70000;
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, 5000000, 5000000));
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, -5000000, 5000000));
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, 5000000, -5000000));
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, 6000000, 6000000));
        t = t + 70000;
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, 6000100, 6000100));
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, -900000000, -1800000000));
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, 900000000, 1800000000));
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, 900000000, -1800000000));
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, -900000000, -1800000000));
        t = t + 70000;
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, -900000000, 1800000000));
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, 900000000, 1800000000));
        t = t + 70000;
        send_fix(mk(1, 0, 1, 1, 4, 1, 1000, t, 900000000, 1800000000));
        walk_now = t;
        walk_lat = 473000000; walk_lon = 85000000;
        run_random(150);
        s_axis_tvalid <= 1'b0;
        drain();

        // Loosest limits, interval write below the minimum, no rejects allowed
        write_all(100, 0, 9999, 65535, 0, 0, 0);
        apb_write(3'd7, 32'hFFFF_FFFF);
        run_random(400);
        s_axis_tvalid <= 1'b0;
        drain();

        // Tightest limits, longest interval
        write_all(86400000, 63, 0, 0, 1048575, 1048575, 255);
        run_random(60);
        s_axis_tvalid <= 1'b0;
        drain();

        // Mid-range settings; one long receiver hold-off fills the block
        repeat (3) begin
            write_all($urandom_range(500, 5000), $urandom_range(3, 8),
                      $urandom_range(200, 2000), $urandom_range(1000, 10000),
                      $urandom_range(0, 3000), $urandom_range(0, 4000), $urandom_range(0, 5));
            hold_ask = hold_ask + 1;
            run_random(345);
            s_axis_tvalid <= 1'b0;
            drain();
        end

        repeat (500) @(posedge i_clk);
        $display("Covered %0d fixes over six register settings, long output stall included.",
                 sent);
        $display("Verdicts: acc %0d forced %0d stale %0d notime %0d sats %0d hdop %0d ivl %0d jump %0d",
                 sb.seen_status[0], sb.seen_status[1], sb.seen_status[2], sb.seen_status[3],
                 sb.seen_status[4], sb.seen_status[5], sb.seen_status[6], sb.seen_status[7]);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #60ms;
        $display("Timeout with %0d results outstanding", sb.owed.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
